@@ sv/tbw_pkg.sv @@
// Shared widths, register indexes and reference codes for the barycentric weight block.
// No dependencies; compiled first.
`default_nettype none

package tbw_pkg;

    // Field widths
    localparam int COORD_W   = 16;  // Q12.4 coordinate
    localparam int DIFF_W    = 17;  // difference of two coordinates
    localparam int PROD_W    = 34;  // product of two differences
    localparam int MAG_W     = 33;  // magnitude of a cross product
    localparam int WEIGHT_W  = 32;  // output weight
    localparam int REF_W     = 2;
    localparam int CFG_IDX_W = 3;

    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    localparam logic signed [WEIGHT_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WEIGHT_W-1:0] SAT_MIN = 32'sh8000_0000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_V0_X = 3'd0,
        CFG_V0_Y = 3'd1,
        CFG_V1_X = 3'd2,
        CFG_V1_Y = 3'd3,
        CFG_V2_X = 3'd4,
        CFG_V2_Y = 3'd5
    } t_cfg_reg;

    // Reference vertex codes; any other code selects vertex 0
    localparam logic [REF_W-1:0] REF_V1 = 2'd1;
    localparam logic [REF_W-1:0] REF_V2 = 2'd2;

endpackage

`default_nettype wire

@@ sv/triangle_barycentric_weights.sv @@
// Top level of the barycentric weight block: vertex registers, triangle setup,
// point pipeline, rounding and clamping, output skid. Uses tbw_pkg and tbw_div.
`default_nettype none

// Barycentric weights of a point against a triangle held in six vertex registers.
// The block accepts one point per clock while o_in_stall is low and returns one result per point,
// in order. The divider resolves one quotient bit per pipeline stage for both weights at
// once; ahead of it lie three front stages, behind it two rounding/clamping stages and
// the output register. The configuration port is always ready; a point accepted in the
// cycle after the last vertex write already sees the new triangle. Weights are rounded
// to nearest, ties away from zero, and clamped to 32 bits; a zero-area triangle returns
// zero weights and the degenerate flag. Input stall rises only after the output has
// been held.
module triangle_barycentric_weights
    import tbw_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [COORD_W-1:0]          i_cfg_data,
    // point request
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [COORD_W-1:0]   i_point_x,
    input  logic signed [COORD_W-1:0]   i_point_y,
    input  logic [REF_W-1:0]            i_ref_vertex,
    // weight result
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [WEIGHT_W-1:0]  o_weight_v,
    output logic signed [WEIGHT_W-1:0]  o_weight_u,
    output logic signed [WEIGHT_W-1:0]  o_weight_w,
    output logic                        o_degenerate,
    output logic                        o_saturated
);

    localparam int NUM_W = MAG_W + WEIGHT_FRAC_BITS;  // scaled numerator / quotient
    localparam int SW    = NUM_W + 2;                 // signed rounded weight
    localparam int FW    = SW + 2;                    // signed w before clamping

    localparam logic signed [FW-1:0] W_ONE = FW'(2 ** WEIGHT_FRAC_BITS);
    localparam logic signed [FW-1:0] W_MAX = FW'(SAT_MAX);
    localparam logic signed [FW-1:0] W_MIN = FW'(SAT_MIN);

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] v;
        logic signed [WEIGHT_W-1:0] u;
        logic signed [WEIGHT_W-1:0] w;
        logic                       deg;
        logic                       sat;
    } t_result;

    // Clamp to 32 bits; top bit flags saturation
    function automatic logic [WEIGHT_W:0] clamp32(input logic signed [FW-1:0] x);
        logic hi;
        logic lo;
        hi = (x > W_MAX);
        lo = (x < W_MIN);
        return {hi | lo, hi ? SAT_MAX : (lo ? SAT_MIN : x[WEIGHT_W-1:0])};
    endfunction

    // ------------------------------------------------------------------
    // Vertex registers
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] r_v0_x, r_v0_y, r_v1_x, r_v1_y, r_v2_x, r_v2_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0_x <= '0;
            r_v0_y <= '0;
            r_v1_x <= '0;
            r_v1_y <= '0;
            r_v2_x <= '0;
            r_v2_y <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_V0_X: r_v0_x <= i_cfg_data;
                CFG_V0_Y: r_v0_y <= i_cfg_data;
                CFG_V1_X: r_v1_x <= i_cfg_data;
                CFG_V1_Y: r_v1_y <= i_cfg_data;
                CFG_V2_X: r_v2_x <= i_cfg_data;
                CFG_V2_Y: r_v2_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Triangle setup: edge vectors, determinant products, zero flag, |det| and sign
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [PROD_W-1:0] r_det_p0, r_det_p1;
    logic [MAG_W-1:0]         r_det_mag;
    logic                     r_det_neg;
    logic                     r_det_zero;
    logic signed [PROD_W-1:0] det;

    assign det = r_det_p0 - r_det_p1;

    always_ff @(posedge i_clk) begin
        r_ax       <= DIFF_W'(r_v2_x) - DIFF_W'(r_v0_x);
        r_ay       <= DIFF_W'(r_v2_y) - DIFF_W'(r_v0_y);
        r_bx       <= DIFF_W'(r_v1_x) - DIFF_W'(r_v0_x);
        r_by       <= DIFF_W'(r_v1_y) - DIFF_W'(r_v0_y);
        r_det_p0   <= PROD_W'(r_ax) * PROD_W'(r_by);
        r_det_p1   <= PROD_W'(r_ay) * PROD_W'(r_bx);
        r_det_mag  <= det[PROD_W-1] ? MAG_W'(-det) : MAG_W'(det);
        r_det_neg  <= det[PROD_W-1];
        r_det_zero <= (det == '0);
    end

    // ------------------------------------------------------------------
    // Pipeline enable and output skid state
    // ------------------------------------------------------------------
    logic    r_sk_vld, n_sk_vld;
    logic    r_out_vld, n_out_vld;
    t_result r_sk, n_sk;
    t_result r_out, n_out;
    logic    en;

    assign en         = !r_sk_vld;
    assign o_in_stall = r_sk_vld;

    // ------------------------------------------------------------------
    // Stage 1: point minus reference vertex
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] ref_x, ref_y;
    logic signed [DIFF_W-1:0]  r_s1_px, r_s1_py;
    logic                      r_s1_vld;

    always_comb begin
        case (i_ref_vertex)
            REF_V1: begin
                ref_x = r_v1_x;
                ref_y = r_v1_y;
            end
            REF_V2: begin
                ref_x = r_v2_x;
                ref_y = r_v2_y;
            end
            default: begin
                ref_x = r_v0_x;
                ref_y = r_v0_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_px <= DIFF_W'(i_point_x) - DIFF_W'(ref_x);
            r_s1_py <= DIFF_W'(i_point_y) - DIFF_W'(ref_y);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cross product terms
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] r_s2_m0, r_s2_m1, r_s2_m2, r_s2_m3;
    logic                     r_s2_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_m0 <= PROD_W'(r_s1_px) * PROD_W'(r_by);
            r_s2_m1 <= PROD_W'(r_s1_py) * PROD_W'(r_bx);
            r_s2_m2 <= PROD_W'(r_ax) * PROD_W'(r_s1_py);
            r_s2_m3 <= PROD_W'(r_ay) * PROD_W'(r_s1_px);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: cross products to sign and magnitude
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] cv, cu;
    logic [MAG_W-1:0]         r_s3_mag_v, r_s3_mag_u;
    logic                     r_s3_neg_v, r_s3_neg_u;
    logic                     r_s3_vld;

    assign cv = r_s2_m0 - r_s2_m1;
    assign cu = r_s2_m2 - r_s2_m3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_mag_v <= cv[PROD_W-1] ? MAG_W'(-cv) : MAG_W'(cv);
            r_s3_mag_u <= cu[PROD_W-1] ? MAG_W'(-cu) : MAG_W'(cu);
            r_s3_neg_v <= cv[PROD_W-1];
            r_s3_neg_u <= cu[PROD_W-1];
        end
    end

    // Hold valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_in_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // ------------------------------------------------------------------
    // Divider: |cross| * 2^WEIGHT_FRAC_BITS / |det|
    // ------------------------------------------------------------------
    logic                   div_vld;
    logic [1:0][NUM_W-1:0]  div_num;
    logic [1:0][NUM_W-1:0]  div_quo;
    logic [1:0][MAG_W-1:0]  div_rem;
    logic [1:0]             div_side;

    assign div_num[0] = {r_s3_mag_v, WEIGHT_FRAC_BITS'(0)};
    assign div_num[1] = {r_s3_mag_u, WEIGHT_FRAC_BITS'(0)};

    tbw_div #(
        .NUM_W (NUM_W),
        .DEN_W (MAG_W),
        .SB_W  (2)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_vld),
        .i_num   (div_num),
        .i_den   (r_det_mag),
        .i_side  ({r_s3_neg_u, r_s3_neg_v}),
        .o_valid (div_vld),
        .o_quo   (div_quo),
        .o_rem   (div_rem),
        .o_side  (div_side)
    );

    // ------------------------------------------------------------------
    // Rounding stage: round half away from zero, apply sign
    // ------------------------------------------------------------------
    logic [1:0][SW-1:0]  rnd_val;
    logic signed [SW-1:0] r_r_v, r_r_u;
    logic                 r_r_vld;

    always_comb begin
        logic [NUM_W:0] qr;
        logic           up;
        logic           neg;
        for (int k = 0; k < 2; k++) begin
            up  = ({div_rem[k], 1'b0} >= {1'b0, r_det_mag});
            qr  = (NUM_W+1)'(div_quo[k]) + (NUM_W+1)'(up);
            neg = div_side[k] ^ r_det_neg;
            rnd_val[k] = neg ? -SW'(qr) : SW'(qr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r_v <= rnd_val[0];
            r_r_u <= rnd_val[1];
        end
    end

    // ------------------------------------------------------------------
    // Final stage: w, clamping, degenerate case
    // ------------------------------------------------------------------
    logic signed [FW-1:0] w_full;
    logic [WEIGHT_W:0]    cl_v, cl_u, cl_w;
    t_result              fin;
    t_result              r_f;
    logic                 r_f_vld;

    assign w_full = W_ONE - FW'(r_r_v) - FW'(r_r_u);
    assign cl_v   = clamp32(FW'(r_r_v));
    assign cl_u   = clamp32(FW'(r_r_u));
    assign cl_w   = clamp32(w_full);

    always_comb begin
        if (r_det_zero) begin
            fin.v   = '0;
            fin.u   = '0;
            fin.w   = '0;
            fin.deg = 1'b1;
            fin.sat = 1'b0;
        end else begin
            fin.v   = cl_v[WEIGHT_W-1:0];
            fin.u   = cl_u[WEIGHT_W-1:0];
            fin.w   = cl_w[WEIGHT_W-1:0];
            fin.deg = 1'b0;
            fin.sat = cl_v[WEIGHT_W] | cl_u[WEIGHT_W] | cl_w[WEIGHT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f <= fin;
        end
    end

    // Hold valid bits of the back stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_r_vld <= div_vld;
            r_f_vld <= r_r_vld;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid: park a result when the output is held
    // ------------------------------------------------------------------
    logic push;
    logic take;

    assign push = en && r_f_vld;
    assign take = r_out_vld && !i_out_stall;

    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        n_sk_vld  = r_sk_vld;
        n_sk      = r_sk;
        if (!r_out_vld || take) begin
            if (r_sk_vld) begin
                n_out_vld = 1'b1;
                n_out     = r_sk;
                n_sk_vld  = 1'b0;
            end else if (push) begin
                n_out_vld = 1'b1;
                n_out     = r_f;
            end else begin
                n_out_vld = 1'b0;
            end
        end else if (push) begin
            n_sk_vld = 1'b1;
            n_sk     = r_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_sk_vld  <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            r_sk_vld  <= n_sk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_sk  <= n_sk;
    end

    assign o_out_valid  = r_out_vld;
    assign o_weight_v   = r_out.v;
    assign o_weight_u   = r_out.u;
    assign o_weight_w   = r_out.w;
    assign o_degenerate = r_out.deg;
    assign o_saturated  = r_out.sat;

endmodule

`default_nettype wire

@@ sv/tbw_div.sv @@
// Pipelined restoring divider: two numerators over one shared divisor, one quotient
// bit per stage, with a valid bit and a sideband that travel alongside. No package needed.
`default_nettype none

module tbw_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33,
    parameter int SB_W  = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [1:0][NUM_W-1:0]       i_num,
    input  logic [DEN_W-1:0]            i_den,
    input  logic [SB_W-1:0]             i_side,
    output logic                        o_valid,
    output logic [1:0][NUM_W-1:0]       o_quo,
    output logic [1:0][DEN_W-1:0]       o_rem,
    output logic [SB_W-1:0]             o_side
);

    localparam int STAGES = NUM_W;

    logic [1:0][DEN_W-1:0] r_rem [STAGES];
    logic [1:0][NUM_W-1:0] r_nq  [STAGES];
    logic                  r_vld [STAGES];
    logic [SB_W-1:0]       r_sb  [STAGES];

    wire  [1:0][DEN_W-1:0] n_rem [STAGES];
    wire  [1:0][NUM_W-1:0] n_nq  [STAGES];

    // One quotient bit per stage; nq shifts the numerator out and the quotient in
    genvar s, l;
    for (s = 0; s < STAGES; s++) begin : g_stage
        logic [1:0][DEN_W-1:0] rem_in;
        logic [1:0][NUM_W-1:0] nq_in;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = i_num;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign nq_in  = r_nq[s-1];
        end

        for (l = 0; l < 2; l++) begin : g_lane
            logic [DEN_W:0] trial;
            logic [DEN_W:0] diff;

            assign trial = {rem_in[l], nq_in[l][NUM_W-1]};
            assign diff  = trial - {1'b0, i_den};
            assign n_rem[s][l] = diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
            assign n_nq[s][l]  = {nq_in[l][NUM_W-2:0], ~diff[DEN_W]};
        end
    end

    // Advance the data path
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
            end
            r_sb[0] <= i_side;
            for (int k = 1; k < STAGES; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_quo   = r_nq[STAGES-1];
    assign o_rem   = r_rem[STAGES-1];
    assign o_side  = r_sb[STAGES-1];

endmodule

`default_nettype wire

@@ sv/tbw_chk.sv @@
// Port-level checker for the barycentric weight block, bound to the top level.
// Depends on tbw_pkg and triangle_barycentric_weights.
`default_nettype none

module tbw_chk
    import tbw_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [COORD_W-1:0]          i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        o_in_stall,
    input  logic signed [COORD_W-1:0]   i_point_x,
    input  logic signed [COORD_W-1:0]   i_point_y,
    input  logic [REF_W-1:0]            i_ref_vertex,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic signed [WEIGHT_W-1:0]  o_weight_v,
    input  logic signed [WEIGHT_W-1:0]  o_weight_u,
    input  logic signed [WEIGHT_W-1:0]  o_weight_w,
    input  logic                        o_degenerate,
    input  logic                        o_saturated
);

    localparam logic [WEIGHT_W-1:0] ONE = WEIGHT_W'(2 ** WEIGHT_FRAC_BITS);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_weight_v) && $stable(o_weight_u) && $stable(o_weight_w)
            && $stable(o_degenerate) && $stable(o_saturated))
        else $error("stalled result changed");

    // Back-pressure upstream only after the output was held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // Degenerate triangle gives zero weights, no saturation
    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |->
            o_weight_v == '0 && o_weight_u == '0 && o_weight_w == '0 && !o_saturated)
        else $error("degenerate result carries weights");

    // Unclamped weights sum to one
    a_sum_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_degenerate && !o_saturated |->
            WEIGHT_W'(o_weight_v + o_weight_u + o_weight_w) == ONE)
        else $error("weights do not sum to one");

endmodule

bind triangle_barycentric_weights tbw_chk #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
) u_tbw_chk (.*);

`default_nettype wire
